@@ design/frame_bitmap_allocator_top_macros.svh @@
// Assertion macros used by the checker in fba_checker.sv.
`ifndef FRAME_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define FBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset.
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/fba_pkg.sv @@
`timescale 1ns / 1ps

package fba_pkg;

  localparam int MAX_FRAMES   = 4096;
  localparam int WORD_BITS    = 32;
  localparam int BITMAP_WORDS = MAX_FRAMES / WORD_BITS;
  localparam int WORD_IDX_W   = $clog2(BITMAP_WORDS);
  localparam int BIT_IDX_W    = $clog2(WORD_BITS);
  localparam int FRAME_W      = 12;
  localparam int WIU_W        = 8;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [0:0] REG_WORDS_IN_USE = 1'b0;
  localparam logic [WIU_W-1:0] WIU_RESET = WIU_W'(BITMAP_WORDS);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [2:0] {
    STAT_ALLOCATED = 3'd0,
    STAT_MAPPED    = 3'd1,
    STAT_NO_FRAMES = 3'd2,
    STAT_FREED     = 3'd3,
    STAT_NOTHING   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE_RD,
    S_FREE_WR,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  rd_en;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_addr;
    logic [WORD_BITS-1:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               rw;
    logic               user;
    status_t            status;
  } res_t;

  function automatic logic [BIT_IDX_W-1:0] onehot_index(input logic [WORD_BITS-1:0] oh);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      idx = idx | (oh[j] ? BIT_IDX_W'(j) : '0);
    end
    return idx;
  endfunction

endpackage

@@ design/fba_bitmap_ram.sv @@
`timescale 1ns / 1ps

module fba_bitmap_ram (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fba_pkg::mem_req_t                  req,
  output logic [fba_pkg::WORD_BITS-1:0]      rdata
);
  import fba_pkg::*;

  logic [WORD_BITS-1:0]    mem [BITMAP_WORDS];
  logic [BITMAP_WORDS-1:0] vld_r;
  logic [BITMAP_WORDS-1:0] vld_nxt;
  logic [WORD_BITS-1:0]    data_r;
  logic                    data_vld_r;

  // A word that was never written since reset reads as all frames free.
  always_comb begin
    vld_nxt = vld_r;
    if (req.wr_en) begin
      vld_nxt[req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      data_r     <= mem[req.rd_addr];
      data_vld_r <= vld_r[req.rd_addr];
    end
  end

  assign rdata = data_vld_r ? data_r : '0;

endmodule

@@ design/fba_ctrl.sv @@
`timescale 1ns / 1ps

module fba_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [fba_pkg::WIU_W-1:0]         words_in_use,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [fba_pkg::FRAME_W-1:0]       in_frame_in,
  input  logic                              in_is_kernel,
  input  logic                              in_is_writeable,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fba_pkg::res_t                     out_res,
  output fba_pkg::mem_req_t                 mem_req,
  input  logic [fba_pkg::WORD_BITS-1:0]     mem_rdata
);
  import fba_pkg::*;

  localparam logic [WIU_W-1:0] WORDS_LIMIT = WIU_W'(BITMAP_WORDS);

  state_t                state_r, state_nxt;
  logic [FRAME_W-1:0]    frame_r, frame_nxt;
  logic                  kern_r, kern_nxt;
  logic                  wr_r, wr_nxt;
  logic [WIU_W-1:0]      limit_r, limit_nxt;
  logic [WIU_W-1:0]      scan_addr_r, scan_addr_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [WORD_IDX_W-1:0] chk_addr_r, chk_addr_nxt;
  res_t                  res_r, res_nxt;
  res_t                  out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  accept;
  logic [WIU_W-1:0]      lim_in;
  logic                  word_full;
  logic [WORD_BITS-1:0]  isolate;
  logic [BIT_IDX_W-1:0]  bit_idx;
  logic                  last_word;
  logic                  found;
  logic                  exhausted;
  logic                  slot_free;
  logic                  scan_rd;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign lim_in    = (words_in_use > WORDS_LIMIT) ? WORDS_LIMIT : words_in_use;
  assign word_full = (mem_rdata == '1);
  assign isolate   = ~mem_rdata & (mem_rdata + WORD_BITS'(1));
  assign bit_idx   = onehot_index(isolate);
  assign last_word = ((WIU_W'(chk_addr_r) + WIU_W'(1)) == limit_r);
  assign found     = chk_vld_r && !word_full;
  assign exhausted = chk_vld_r && word_full && last_word;
  assign slot_free = !out_valid_r || out_ready;
  assign scan_rd   = (scan_addr_r < limit_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_FREE) begin
            state_nxt = (in_frame_in == '0) ? S_DONE : S_FREE_RD;
          end else if (in_frame_in != '0 || lim_in == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_FREE_RD: state_nxt = S_FREE_WR;
      S_FREE_WR: state_nxt = S_DONE;
      S_SCAN: begin
        if (found || exhausted) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    frame_nxt     = frame_r;
    kern_nxt      = kern_r;
    wr_nxt        = wr_r;
    limit_nxt     = limit_r;
    scan_addr_nxt = scan_addr_r;
    chk_vld_nxt   = 1'b0;
    chk_addr_nxt  = chk_addr_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_req       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          frame_nxt     = in_frame_in;
          kern_nxt      = in_is_kernel;
          wr_nxt        = in_is_writeable;
          limit_nxt     = lim_in;
          scan_addr_nxt = '0;
          res_nxt       = '{frame: '0, present: 1'b0, rw: 1'b0, user: 1'b0,
                            status: STAT_NO_FRAMES};
          if (in_req_type == REQ_FREE) begin
            res_nxt.status = STAT_NOTHING;
          end else if (in_frame_in != '0) begin
            res_nxt.frame  = in_frame_in;
            res_nxt.status = STAT_MAPPED;
          end
        end
      end
      S_FREE_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = frame_r[FRAME_W-1:BIT_IDX_W];
      end
      S_FREE_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = frame_r[FRAME_W-1:BIT_IDX_W];
        mem_req.wdata   = mem_rdata & ~(WORD_BITS'(1) << frame_r[BIT_IDX_W-1:0]);
        res_nxt.status  = STAT_FREED;
      end
      S_SCAN: begin
        if (!found && !exhausted && scan_rd) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = scan_addr_r[WORD_IDX_W-1:0];
          scan_addr_nxt   = scan_addr_r + WIU_W'(1);
          chk_vld_nxt     = 1'b1;
          chk_addr_nxt    = scan_addr_r[WORD_IDX_W-1:0];
        end
        if (found) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = chk_addr_r;
          mem_req.wdata   = mem_rdata | isolate;
          res_nxt.frame   = {chk_addr_r, bit_idx};
          res_nxt.present = 1'b1;
          res_nxt.rw      = wr_r;
          res_nxt.user    = !kern_r;
          res_nxt.status  = STAT_ALLOCATED;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r     <= frame_nxt;
    kern_r      <= kern_nxt;
    wr_r        <= wr_nxt;
    limit_r     <= limit_nxt;
    scan_addr_r <= scan_addr_nxt;
    chk_addr_r  <= chk_addr_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

@@ design/frame_bitmap_allocator_top.sv @@
`timescale 1ns / 1ps
// Page-frame allocator over a 4096-frame used bitmap held in a 128 x 32 memory.
// A free request reads its bitmap word and writes it back with the bit cleared;
// a free of frame zero, an allocate of a held frame, or one with no words to
// search goes straight to the result. A searching allocate reads bitmap words
// up to and including the first word with a clear bit, or every searched word
// when none has one (at most words_in_use, capped at 128). The single memory
// read port delivers one word per cycle. One item is in
// process at a time; the next transfer is taken as soon as the result is in the
// output register. The bitmap reads as all free right after reset without a
// clearing pass.

module frame_bitmap_allocator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fba_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [fba_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [fba_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [fba_pkg::FRAME_W-1:0]     in_frame_in,
  input  logic                            in_is_kernel,
  input  logic                            in_is_writeable,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fba_pkg::FRAME_W-1:0]     out_frame_out,
  output logic                            out_present,
  output logic                            out_rw_flag,
  output logic                            out_user_flag,
  output logic [2:0]                      out_status
);
  import fba_pkg::*;

  logic [WIU_W-1:0]     wiu_r, wiu_nxt;
  logic                 reg_sel;
  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] mem_rdata;
  res_t                 out_res;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_WORDS_IN_USE);

  always_comb begin
    wiu_nxt = wiu_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      wiu_nxt = cfg_pwdata[WIU_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wiu_r <= WIU_RESET;
    end else begin
      wiu_r <= wiu_nxt;
    end
  end

  assign cfg_prdata = reg_sel ? CFG_DATA_W'(wiu_r) : '0;

  fba_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .words_in_use   (wiu_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_frame_in    (in_frame_in),
    .in_is_kernel   (in_is_kernel),
    .in_is_writeable(in_is_writeable),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_res        (out_res),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  fba_bitmap_ram u_ram (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mem_req),
    .rdata(mem_rdata)
  );

  assign out_frame_out = out_res.frame;
  assign out_present   = out_res.present;
  assign out_rw_flag   = out_res.rw;
  assign out_user_flag = out_res.user;
  assign out_status    = out_res.status;

endmodule

@@ design/fba_checker.sv @@
`timescale 1ns / 1ps
`include "frame_bitmap_allocator_top_macros.svh"

module fba_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [fba_pkg::FRAME_W-1:0]     out_frame_out,
  input logic                            out_present,
  input logic                            out_rw_flag,
  input logic                            out_user_flag,
  input logic [2:0]                      out_status
);
  import fba_pkg::*;

  `FBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_frame_out) && $stable(out_status), "Stalled result changed before its transfer.")

  `FBA_ASSERT_SAME(a_flags_clear, out_valid && out_status != STAT_ALLOCATED, !out_present && !out_rw_flag && !out_user_flag, "Page flags set on a result that allocated nothing.")

  `FBA_ASSERT_SAME(a_zero_frame, out_valid && (out_status == STAT_NO_FRAMES || out_status == STAT_FREED || out_status == STAT_NOTHING), out_frame_out == '0, "Result without a held frame reports a nonzero frame.")

  `FBA_ASSERT_SAME(a_mapped_frame, out_valid && out_status == STAT_MAPPED, out_frame_out != '0, "Already mapped result reports frame zero.")

endmodule

bind frame_bitmap_allocator_top fba_checker u_fba_checker (.*);

@@ tb/frame_alloc_checker.sv @@
`timescale 1ns / 1ps

module frame_alloc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic                           cfg_pready,
  input  logic [fba_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [fba_pkg::FRAME_W-1:0]    in_frame_in,
  input  logic                           in_is_kernel,
  input  logic                           in_is_writeable,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [fba_pkg::FRAME_W-1:0]    out_frame_out,
  input  logic                           out_present,
  input  logic                           out_rw_flag,
  input  logic                           out_user_flag,
  input  logic [2:0]                     out_status,
  input  logic                           drain_done,
  output int                             fail_count
);
  import fba_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] WIU_ADDR = CFG_ADDR_W'(4 * REG_WORDS_IN_USE);

  logic [WORD_BITS-1:0] frame_used [BITMAP_WORDS];
  logic [WIU_W-1:0]     words_cfg;
  res_t                 pending_results [$];
  res_t                 oldest;
  logic                 leftovers_checked;

  // Mirrors one request against the bitmap copy and returns the page entry it leaves.
  function automatic res_t predict_alloc(input logic req, input logic [FRAME_W-1:0] fin,
                                         input logic kern, input logic wr);
    res_t r;
    int   span;
    int   hit;
    r = '0;
    if (req == REQ_ALLOC) begin
      if (fin != '0) begin
        r.frame  = fin;
        r.status = STAT_MAPPED;
      end else begin
        span = (words_cfg > BITMAP_WORDS) ? BITMAP_WORDS : int'(words_cfg);
        hit  = -1;
        for (int w = 0; w < span; w++) begin
          for (int b = 0; b < WORD_BITS; b++) begin
            if (hit < 0 && !frame_used[w][b]) hit = w * WORD_BITS + b;
          end
        end
        if (hit >= 0) begin
          frame_used[hit / WORD_BITS][hit % WORD_BITS] = 1'b1;
          r.frame   = FRAME_W'(hit);
          r.present = 1'b1;
          r.rw      = wr;
          r.user    = !kern;
          r.status  = STAT_ALLOCATED;
        end else begin
          r.status = STAT_NO_FRAMES;
        end
      end
    end else if (fin == '0) begin
      r.status = STAT_NOTHING;
    end else begin
      frame_used[fin / WORD_BITS][fin % WORD_BITS] = 1'b0;
      r.status = STAT_FREED;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < BITMAP_WORDS; w++) frame_used[w] = '0;
      words_cfg = WIU_RESET;
      pending_results.delete();
      leftovers_checked = 1'b0;
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == WIU_ADDR) begin
        words_cfg = cfg_pwdata[WIU_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("Result transfer with no request outstanding: frame_out %0d, status %0d",
                 out_frame_out, out_status);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          if (oldest.frame !== out_frame_out) begin
            $error("frame_out: expected %0d, actual %0d", oldest.frame, out_frame_out);
            fail_count++;
          end
          if (oldest.present !== out_present) begin
            $error("present: expected %0d, actual %0d", oldest.present, out_present);
            fail_count++;
          end
          if (oldest.rw !== out_rw_flag) begin
            $error("rw_flag: expected %0d, actual %0d", oldest.rw, out_rw_flag);
            fail_count++;
          end
          if (oldest.user !== out_user_flag) begin
            $error("user_flag: expected %0d, actual %0d", oldest.user, out_user_flag);
            fail_count++;
          end
          if (oldest.status !== out_status) begin
            $error("status: expected %0d, actual %0d", oldest.status, out_status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(predict_alloc(in_req_type, in_frame_in, in_is_kernel,
                                                in_is_writeable));
      end
      if (drain_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (pending_results.size() != 0) begin
          $error("%0d results never arrived", pending_results.size());
          fail_count += pending_results.size();
          pending_results.delete();
        end
      end
    end
  end

endmodule

@@ tb/frame_bitmap_allocator_top_tb.sv @@
`timescale 1ns / 1ps

module frame_bitmap_allocator_top_tb;
  import fba_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] WIU_ADDR = CFG_ADDR_W'(4 * REG_WORDS_IN_USE);
  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 58;
  localparam int HOLD_AT    = 230;
  localparam int HOLD_LEN   = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_req_type;
  logic [FRAME_W-1:0]    in_frame_in;
  logic                  in_is_kernel;
  logic                  in_is_writeable;
  logic                  out_valid;
  logic                  out_ready;
  logic [FRAME_W-1:0]    out_frame_out;
  logic                  out_present;
  logic                  out_rw_flag;
  logic                  out_user_flag;
  logic [2:0]            out_status;
  logic                  drain_done;
  int                    fail_count;

  int   sent;
  int   got;
  int   settings_done;
  int   status_seen [5];
  int   words_now;
  int   words_plan [PHASES];
  bit   calm;
  bit   held;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  frame_bitmap_allocator_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_frame_in    (in_frame_in),
    .in_is_kernel   (in_is_kernel),
    .in_is_writeable(in_is_writeable),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_out  (out_frame_out),
    .out_present    (out_present),
    .out_rw_flag    (out_rw_flag),
    .out_user_flag  (out_user_flag),
    .out_status     (out_status)
  );

  frame_alloc_checker alloc_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_pready     (cfg_pready),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_frame_in    (in_frame_in),
    .in_is_kernel   (in_is_kernel),
    .in_is_writeable(in_is_writeable),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_out  (out_frame_out),
    .out_present    (out_present),
    .out_rw_flag    (out_rw_flag),
    .out_user_flag  (out_user_flag),
    .out_status     (out_status),
    .drain_done     (drain_done),
    .fail_count     (fail_count)
  );

  task automatic issue(input logic req, input logic [FRAME_W-1:0] fin, input logic kern,
                       input logic wr);
    if (!calm) begin
      while ($urandom_range(0, 99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_frame_in     <= fin;
    in_is_kernel    <= kern;
    in_is_writeable <= wr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (sent != got) @(posedge clk);
  endtask

  task automatic write_words(input int v);
    wait_results();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= WIU_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    words_now = v;
    settings_done++;
  endtask

  // Most frees aim at the low frames, where first-fit allocation sets used bits.
  task automatic random_request();
    int pick;
    int eff;
    int hi;
    pick = $urandom_range(0, 99);
    eff  = (words_now > BITMAP_WORDS) ? BITMAP_WORDS : words_now;
    hi   = (eff == 0) ? 31 : 32 * ((eff > 6) ? 6 : eff) - 1;
    if (pick < 55) begin
      issue(REQ_ALLOC, '0, 1'($urandom), 1'($urandom));
    end else if (pick < 85) begin
      issue(REQ_FREE, FRAME_W'($urandom_range(0, hi)), 1'($urandom), 1'($urandom));
    end else if (pick < 93) begin
      issue(REQ_ALLOC, FRAME_W'($urandom_range(1, 4095)), 1'($urandom), 1'($urandom));
    end else if (pick < 98) begin
      issue(REQ_FREE, FRAME_W'($urandom_range(1, 4095)), 1'($urandom), 1'($urandom));
    end else begin
      issue(REQ_FREE, '0, 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got++;
        if (out_status < 3'd5) status_seen[out_status]++;
      end
      if (!held && got == HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 9);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    in_valid        <= 1'b0;
    in_req_type     <= REQ_ALLOC;
    in_frame_in     <= '0;
    in_is_kernel    <= 1'b0;
    in_is_writeable <= 1'b0;
    drain_done      <= 1'b0;
    words_now = WIU_RESET;
    words_plan = '{1, 3, 128, 2, 255, 0, 8, 128, 5, 4};
    words_plan[8] = $urandom_range(1, 6);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Frame zero is handed out first and cannot be freed afterwards.
    issue(REQ_ALLOC, '0, 1'b0, 1'b1);
    issue(REQ_ALLOC, '0, 1'b1, 1'b0);
    issue(REQ_ALLOC, '0, 1'b1, 1'b1);
    issue(REQ_ALLOC, '0, 1'b0, 1'b0);
    issue(REQ_ALLOC, FRAME_W'(4095), 1'b0, 1'b1);
    issue(REQ_ALLOC, FRAME_W'(1), 1'b0, 1'b0);
    issue(REQ_ALLOC, FRAME_W'(2048), 1'b1, 1'b1);
    issue(REQ_FREE, '0, 1'b1, 1'b1);
    issue(REQ_FREE, FRAME_W'(2), 1'b0, 1'b0);
    issue(REQ_FREE, FRAME_W'(4095), 1'b1, 1'b0);
    issue(REQ_ALLOC, '0, 1'b1, 1'b1);
    issue(REQ_FREE, FRAME_W'(1), 1'b1, 1'b1);
    issue(REQ_FREE, FRAME_W'(3), 1'b0, 1'b1);
    write_words(0);
    issue(REQ_ALLOC, '0, 1'b0, 1'b1);
    issue(REQ_FREE, FRAME_W'(2), 1'b0, 1'b0);
    issue(REQ_ALLOC, '0, 1'b1, 1'b0);
    write_words(1);
    issue(REQ_ALLOC, '0, 1'b0, 1'b1);
    issue(REQ_ALLOC, '0, 1'b1, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      write_words(words_plan[p]);
      calm = (p == 2);
      for (int i = 0; i < PHASE_LEN; i++) random_request();
    end
    calm = 1'b0;

    wait_results();
    repeat (150) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Covered %0d requests across %0d word-count settings from 0 to 255.",
             sent, settings_done);
    $display("Results: allocated %0d, mapped %0d, out of frames %0d, freed %0d, none to free %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
